FILE: rtl/lzd_pkg.sv
// ============================================================================
// lzd_pkg: shared types and constants of the LZ10/LZ11 decompressor
// Word layouts of both channels, the decode command and the stream codes.
// ============================================================================
package lzd_pkg;

  localparam int WINDOW_SIZE_DEF = 4096;

  // Field widths fixed by the stream format.
  localparam int SIZE_W = 32;
  localparam int DIST_W = 13;
  localparam int LEN_W  = 17;

  // Header type bytes.
  localparam logic [7:0] TYPE_LZ10 = 8'h10;
  localparam logic [7:0] TYPE_LZ11 = 8'h11;

  // Copy length biases.
  localparam logic [LEN_W-1:0] LZ10_LEN_BIAS   = LEN_W'(3);
  localparam logic [LEN_W-1:0] LZ11_MID_BIAS   = LEN_W'(17);
  localparam logic [LEN_W-1:0] LZ11_LONG_BIAS  = LEN_W'(273);
  localparam logic [LEN_W-1:0] LZ11_SHORT_BIAS = LEN_W'(1);

  // LZ11 token size selectors (high nibble of the first token byte).
  localparam logic [3:0] LZ11_IND_MID  = 4'h0;
  localparam logic [3:0] LZ11_IND_LONG = 4'h1;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_TYPE = 2'd1;
  localparam logic [1:0] ST_BAD_REF  = 2'd2;
  localparam logic [1:0] ST_TRUNC    = 2'd3;

  typedef struct packed {
    logic       in_valid;
    logic [7:0] in_byte;
    logic       in_last;
  } in_item_t;

  typedef struct packed {
    logic       consumed;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       out_last;
    logic [1:0] status;
  } out_item_t;

  // Decode result of one word, handed from the parser to the data path.
  typedef struct packed {
    logic       consumed;
    logic       emit;
    logic       from_history;
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
  } cmd_t;

endpackage

FILE: rtl/lzd_stream_if.sv
// ============================================================================
// lzd_stream_if: valid/ready channel
// Carries one word of any packed type per handshake.
// ============================================================================
interface lzd_stream_if #(
  parameter type item_t = logic
) ();

  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

FILE: rtl/lzd_ram.sv
// ============================================================================
// lzd_ram: simple dual-port RAM
// One write port, one read port with registered read data (old data on
// read-during-write). Read data holds while re is low.
// ============================================================================
module lzd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lzd_pkg::WINDOW_SIZE_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/lzd_parser.sv
// ============================================================================
// lzd_parser: header, flag and token parser
// Holds the decode state; turns one word into a command plus history
// addresses. State advances only on an accepted word.
// ============================================================================
module lzd_parser #(
  parameter int WINDOW_SIZE = lzd_pkg::WINDOW_SIZE_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           advance,
  input  lzd_pkg::in_item_t              item,
  output lzd_pkg::cmd_t                  cmd,
  output logic [$clog2(WINDOW_SIZE)-1:0] rd_addr,
  output logic [$clog2(WINDOW_SIZE)-1:0] wr_addr
);

  import lzd_pkg::*;

  localparam int AW = $clog2(WINDOW_SIZE);
  localparam int PW = $clog2(WINDOW_SIZE + 1);
  localparam int CW = (PW > DIST_W) ? PW : DIST_W;
  localparam logic [PW-1:0] PROD_MAX = PW'(WINDOW_SIZE);
  localparam logic [AW-1:0] WP_LAST  = AW'(WINDOW_SIZE - 1);
  localparam logic [AW:0]   WIN_EXT  = (AW + 1)'(WINDOW_SIZE);

  typedef enum logic [2:0] {
    PH_TYPE, PH_SIZE, PH_EXT, PH_FLAG, PH_BODY, PH_TOKEN, PH_COPY, PH_DRAIN
  } phase_t;

  phase_t              phase, phase_next;
  logic [1:0]          header_index, header_index_next;
  logic                stream_kind, stream_kind_next;
  logic [SIZE_W-1:0]   bytes_left, bytes_left_next;
  logic [7:0]          flag_byte, flag_byte_next;
  logic [2:0]          flag_index, flag_index_next;
  logic [23:0]         token_bytes, token_bytes_next;
  logic [1:0]          token_count, token_count_next;
  logic [LEN_W-1:0]    copy_left, copy_left_next;
  logic [DIST_W-1:0]   copy_distance, copy_distance_next;
  logic [AW-1:0]       write_pointer, write_pointer_next;
  logic [PW-1:0]       produced_count, produced_count_next;
  logic [1:0]          error_code, error_code_next;
  logic                stream_ended, stream_ended_next;

  logic [7:0]          b;
  logic [AW-1:0]       wp_inc;
  logic [PW-1:0]       prod_inc;
  logic [SIZE_W-1:0]   bytes_dec;
  logic [LEN_W-1:0]    copy_dec;
  logic [AW:0]         back;
  logic [1:0]          size_lane;
  logic [SIZE_W-1:0]   size_or;
  logic                flag_bit;
  logic [7:0]          b0, t1, t2;
  logic [3:0]          ind;
  logic [2:0]          need;
  logic [2:0]          count_p1;
  logic                tok_done;
  logic [LEN_W-1:0]    tok_len;
  logic [DIST_W-1:0]   tok_dist;
  logic                ref_bad;
  logic [23:0]         tb_merge;

  assign b         = item.in_byte;
  assign wp_inc    = (write_pointer == WP_LAST) ? '0 : write_pointer + 1'b1;
  assign prod_inc  = (produced_count == PROD_MAX) ? produced_count
                                                  : produced_count + 1'b1;
  assign bytes_dec = bytes_left - 1'b1;
  assign copy_dec  = (copy_left != '0) ? copy_left - 1'b1 : '0;

  // Copy source, wrapped into the window.
  assign back    = {1'b0, write_pointer} - (AW + 1)'(copy_distance);
  assign rd_addr = back[AW] ? AW'(back + WIN_EXT) : back[AW-1:0];
  assign wr_addr = write_pointer;

  // Size bytes are little endian; the base size starts at header_index 1.
  assign size_lane = (phase == PH_SIZE) ? header_index - 2'd1 : header_index;
  assign size_or   = bytes_left | (SIZE_W'(b) << {size_lane, 3'b000});

  assign flag_bit = flag_byte[3'd7 - flag_index];

  // Reference token assembly.
  assign b0       = token_bytes[7:0];
  assign ind      = b0[7:4];
  assign count_p1 = {1'b0, token_count} + 3'd1;
  assign t1       = (token_count >= 2'd2) ? token_bytes[15:8] : b;
  assign t2       = (token_count == 2'd3) ? token_bytes[23:16] : b;
  assign tb_merge = token_bytes | (24'(b) << {token_count, 3'b000});

  always_comb begin
    if (!stream_kind) begin
      need = 3'd2;
    end else if (ind == LZ11_IND_MID) begin
      need = 3'd3;
    end else if (ind == LZ11_IND_LONG) begin
      need = 3'd4;
    end else begin
      need = 3'd2;
    end
  end

  assign tok_done = (count_p1 >= need);

  always_comb begin
    if (!stream_kind) begin
      tok_len  = LEN_W'(b0[7:4]) + LZ10_LEN_BIAS;
      tok_dist = DIST_W'({b0[3:0], t1}) + 1'b1;
    end else if (ind == LZ11_IND_MID) begin
      tok_len  = LEN_W'({b0[3:0], t1[7:4]}) + LZ11_MID_BIAS;
      tok_dist = DIST_W'({t1[3:0], t2}) + 1'b1;
    end else if (ind == LZ11_IND_LONG) begin
      tok_len  = LEN_W'({b0[3:0], t1, t2[7:4]}) + LZ11_LONG_BIAS;
      tok_dist = DIST_W'({t2[3:0], b}) + 1'b1;
    end else begin
      tok_len  = LEN_W'(ind) + LZ11_SHORT_BIAS;
      tok_dist = DIST_W'({b0[3:0], t1}) + 1'b1;
    end
  end

  assign ref_bad = CW'(tok_dist) > CW'(produced_count);

  always_comb begin
    phase_next          = phase;
    header_index_next   = header_index;
    stream_kind_next    = stream_kind;
    bytes_left_next     = bytes_left;
    flag_byte_next      = flag_byte;
    flag_index_next     = flag_index;
    token_bytes_next    = token_bytes;
    token_count_next    = token_count;
    copy_left_next      = copy_left;
    copy_distance_next  = copy_distance;
    write_pointer_next  = write_pointer;
    produced_count_next = produced_count;
    error_code_next     = error_code;
    stream_ended_next   = stream_ended;
    cmd                 = '0;

    if (phase == PH_COPY) begin
      // Copy has priority; the offered word stays untaken.
      cmd.emit            = 1'b1;
      cmd.from_history    = 1'b1;
      write_pointer_next  = wp_inc;
      produced_count_next = prod_inc;
      copy_left_next      = copy_dec;
      bytes_left_next     = bytes_dec;
      if (bytes_dec == '0) begin
        cmd.last          = 1'b1;
        phase_next        = stream_ended ? PH_TYPE : PH_DRAIN;
        stream_ended_next = 1'b0;
      end else if (copy_dec == '0) begin
        if (flag_index == 3'd7) begin
          flag_index_next = '0;
          phase_next      = PH_FLAG;
        end else begin
          flag_index_next = flag_index + 1'b1;
          phase_next      = PH_BODY;
        end
        if (stream_ended) begin
          error_code_next   = ST_TRUNC;
          phase_next        = PH_TYPE;
          stream_ended_next = 1'b0;
        end
      end
    end else if (item.in_valid) begin
      cmd.consumed = 1'b1;
      unique case (phase)
        PH_TYPE: begin
          error_code_next     = ST_OK;
          produced_count_next = '0;
          write_pointer_next  = '0;
          if (b == TYPE_LZ10 || b == TYPE_LZ11) begin
            stream_kind_next  = b[0];
            bytes_left_next   = '0;
            header_index_next = 2'd1;
            phase_next        = PH_SIZE;
          end else begin
            error_code_next = ST_BAD_TYPE;
            phase_next      = PH_DRAIN;
          end
        end
        PH_SIZE: begin
          bytes_left_next = size_or;
          if (header_index == 2'd3) begin
            header_index_next = '0;
            flag_index_next   = '0;
            phase_next        = (size_or == '0) ? PH_EXT : PH_FLAG;
          end else begin
            header_index_next = header_index + 1'b1;
          end
        end
        PH_EXT: begin
          bytes_left_next = size_or;
          if (header_index == 2'd3) begin
            header_index_next = '0;
            flag_index_next   = '0;
            phase_next        = (size_or == '0) ? PH_DRAIN : PH_FLAG;
          end else begin
            header_index_next = header_index + 1'b1;
          end
        end
        PH_FLAG: begin
          flag_byte_next  = b;
          flag_index_next = '0;
          phase_next      = PH_BODY;
        end
        PH_BODY: begin
          if (!flag_bit) begin
            cmd.emit            = 1'b1;
            cmd.data            = b;
            write_pointer_next  = wp_inc;
            produced_count_next = prod_inc;
            bytes_left_next     = bytes_dec;
            if (bytes_dec == '0) begin
              cmd.last   = 1'b1;
              phase_next = PH_DRAIN;
            end else if (flag_index == 3'd7) begin
              flag_index_next = '0;
              phase_next      = PH_FLAG;
            end else begin
              flag_index_next = flag_index + 1'b1;
              phase_next      = PH_BODY;
            end
          end else begin
            token_bytes_next = 24'(b);
            token_count_next = 2'd1;
            phase_next       = PH_TOKEN;
          end
        end
        PH_TOKEN: begin
          if (tok_done) begin
            token_count_next = '0;
            if (ref_bad) begin
              error_code_next = ST_BAD_REF;
              phase_next      = PH_DRAIN;
            end else begin
              copy_left_next     = tok_len;
              copy_distance_next = tok_dist;
              phase_next         = PH_COPY;
            end
          end else begin
            token_bytes_next = tb_merge;
            token_count_next = token_count + 1'b1;
          end
        end
        default: begin
          // Drain: words are taken and dropped.
        end
      endcase

      if (item.in_last) begin
        if (phase_next == PH_COPY) begin
          stream_ended_next = 1'b1;
        end else begin
          if (phase_next != PH_DRAIN) begin
            error_code_next = ST_TRUNC;
          end
          phase_next = PH_TYPE;
        end
      end
    end

    cmd.status = error_code_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_TYPE;
      header_index   <= '0;
      stream_kind    <= 1'b0;
      bytes_left     <= '0;
      flag_byte      <= '0;
      flag_index     <= '0;
      token_bytes    <= '0;
      token_count    <= '0;
      copy_left      <= '0;
      copy_distance  <= '0;
      write_pointer  <= '0;
      produced_count <= '0;
      error_code     <= ST_OK;
      stream_ended   <= 1'b0;
    end else if (advance) begin
      phase          <= phase_next;
      header_index   <= header_index_next;
      stream_kind    <= stream_kind_next;
      bytes_left     <= bytes_left_next;
      flag_byte      <= flag_byte_next;
      flag_index     <= flag_index_next;
      token_bytes    <= token_bytes_next;
      token_count    <= token_count_next;
      copy_left      <= copy_left_next;
      copy_distance  <= copy_distance_next;
      write_pointer  <= write_pointer_next;
      produced_count <= produced_count_next;
      error_code     <= error_code_next;
      stream_ended   <= stream_ended_next;
    end
  end

endmodule

FILE: rtl/lz10_lz11_stream_decompressor.sv
// ============================================================================
// lz10_lz11_stream_decompressor: LZ10/LZ11 byte stream decompressor
// Parses header, flag and token bytes and rebuilds the output from a
// history window held in a single block RAM.
// ============================================================================
// Usage
//   compressed   : sink channel; each word is one tick of the byte stream
//                  (in_valid / in_byte / in_last). Ticks with in_valid low
//                  are still words and still produce a result word.
//   decompressed : source channel; exactly one result word per input word,
//                  in order (consumed / out_valid / out_byte / out_last /
//                  status). consumed low means the offered byte was not
//                  taken: a back-reference copy emitted instead (the sender
//                  re-offers it in a later word) or in_valid was low.
//   Throughput     : one word per cycle unless the output stalls; copies included.
//   Pipeline       : stage 0 decodes and issues the history read; stage 1
//                    takes the registered RAM data, writes the byte back and
//                    loads the output register that holds the result word.
//   Stalls         : a stalled output register blocks stage 1; ready drops only
//                    when stage 1 is full and the receiver holds a result word.
//   Reset          : parser expects a type byte; history RAM is not cleared,
//                    since a reference is checked against the bytes produced
//                    in the current stream before it may read the window.
//   Hazards        : a copy reading the entry that stage 1 writes in the
//                    same cycle gets the byte forwarded around the RAM.
// ============================================================================
module lz10_lz11_stream_decompressor #(
  parameter int WINDOW_SIZE = lzd_pkg::WINDOW_SIZE_DEF
) (
  input  logic         clk,
  input  logic         rst,
  lzd_stream_if.sink   compressed,
  lzd_stream_if.source decompressed
);

  import lzd_pkg::*;

  localparam int AW = $clog2(WINDOW_SIZE);

  // Stage 0: parser
  cmd_t          cmd;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic          accept;

  // Stage 1: RAM data return and write-back
  logic          s1_valid;
  cmd_t          s1_cmd;
  logic [AW-1:0] s1_waddr;
  logic          s1_fwd;
  logic [7:0]    s1_fwd_data;
  logic [7:0]    ram_q;
  logic [7:0]    s1_byte;
  logic          s1_we;

  // Output register
  logic          o_valid;
  out_item_t     o_item;
  logic          out_free;

  assign out_free         = !o_valid || decompressed.ready;
  assign compressed.ready = !s1_valid || out_free;
  assign accept           = compressed.valid && compressed.ready;

  lzd_parser #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .advance (accept),
    .item    (compressed.data),
    .cmd     (cmd),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr)
  );

  // Byte leaving stage 1: copied from history (or forwarded) or literal.
  assign s1_byte = !s1_cmd.from_history ? s1_cmd.data
                 : s1_fwd               ? s1_fwd_data
                 :                        ram_q;
  assign s1_we   = s1_valid && out_free && s1_cmd.emit;

  lzd_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_SIZE)
  ) u_history (
    .clk   (clk),
    .we    (s1_we),
    .waddr (s1_waddr),
    .wdata (s1_byte),
    .re    (accept && cmd.from_history),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (out_free) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_cmd      <= cmd;
      s1_waddr    <= wr_addr;
      // Same-entry write in this cycle: RAM returns stale data, so forward.
      s1_fwd      <= s1_we && cmd.from_history && (rd_addr == s1_waddr);
      s1_fwd_data <= s1_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (s1_valid && out_free) begin
      o_valid <= 1'b1;
    end else if (decompressed.ready) begin
      o_valid <= 1'b0;
    end
    if (s1_valid && out_free) begin
      o_item.consumed  <= s1_cmd.consumed;
      o_item.out_valid <= s1_cmd.emit;
      o_item.out_byte  <= s1_cmd.emit ? s1_byte : 8'd0;
      o_item.out_last  <= s1_cmd.last;
      o_item.status    <= s1_cmd.status;
    end
  end

  assign decompressed.valid = o_valid;
  assign decompressed.data  = o_item;

  // Forwarding is only ever armed for a history copy.
  a_fwd_copy: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_fwd |-> s1_cmd.from_history)
    else $error("forward flag set on a non-copy word");

  // A copy word emits and never takes the offered byte.
  a_copy_word: assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_cmd.from_history |-> s1_cmd.emit && !s1_cmd.consumed)
    else $error("copy word with bad emit/consume flags");

  // Last marker only on an emitted byte.
  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_item.out_last |-> o_item.out_valid)
    else $error("out_last without out_valid");

  // Both stages full and receiver stalled: no new word may enter.
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    s1_valid && o_valid && !decompressed.ready |-> !compressed.ready)
    else $error("word accepted while pipeline full");

endmodule
